FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define TPLR_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("label resolver assertion failed");
// Check that a condition never holds outside reset.
`define TPLR_NEVER(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("label resolver forbidden condition seen");
`else
`define TPLR_ASSERT(name, prop)
`define TPLR_NEVER(name, cond)
`endif
`endif

FILE: sv/tplr_pkg.sv
// ---------------------------------------------------------------------------
// tplr_pkg
// Types and constants shared by the label resolver front end, queue and back end.
// ---------------------------------------------------------------------------
package tplr_pkg;

   localparam int ATOM_DEPTH  = 4096;
   localparam int TABLE_DEPTH = 256;
   localparam int ATOM_AW     = $clog2(ATOM_DEPTH);
   localparam int CNT_W       = $clog2(ATOM_DEPTH + 1);
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int KIND_W      = 3;
   localparam int IDENT_W     = 8;
   localparam int DATA_W      = 64;
   localparam int POS_W       = 16;
   localparam int BYTE_W      = 8;
   localparam int WORD_BYTES  = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE  = 3'd0,
      KIND_LREF  = 3'd1,
      KIND_VREF  = 3'd2,
      KIND_NUM   = 3'd3,
      KIND_LDEF  = 3'd4,
      KIND_VDEF  = 3'd5,
      KIND_DRAIN = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ATOM_BYTE = 2'd0,
      ATOM_LREF = 2'd1,
      ATOM_VREF = 2'd2,
      ATOM_NUM  = 2'd3
   } atom_kind_type;

   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_TDEF  = 2'd1,
      CMD_DRAIN = 2'd2,
      CMD_EMPTY = 2'd3
   } cmd_op_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_ATOM  = 2'd1,
      BK_TABLE = 2'd2
   } back_state_type;

   typedef struct packed {
      cmd_op_type             op;
      atom_kind_type          atom_kind;
      logic [ATOM_AW-1:0]     addr;
      logic [TABLE_AW-1:0]    tbl_idx;
      logic [DATA_W-1:0]      data;
      logic                   final_atom;
      logic                   overflowed;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      atom_kind_type      kind;
      logic [DATA_W-1:0]  payload;
   } atom_type;

endpackage

FILE: sv/tplr_front.sv
// ---------------------------------------------------------------------------
// tplr_front
// Accepts requests, tracks position/count/pointer and issues back-end commands.
// ---------------------------------------------------------------------------
module tplr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tplr_pkg::KIND_W-1:0]   req_kind,
   input  logic [tplr_pkg::IDENT_W-1:0]  req_ident,
   input  logic [tplr_pkg::DATA_W-1:0]   req_payload,
   input  tplr_pkg::q_status_type        q_status,
   output logic                          busy,
   output logic                          push,
   output tplr_pkg::cmd_type             push_cmd
);

   logic [tplr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [tplr_pkg::CNT_W-1:0] rp_ff, rp_in;
   logic [tplr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       draining_ff, draining_in;
   logic                       ovf_ff, ovf_in;

   logic                       accept;
   logic [tplr_pkg::CNT_W-1:0] base_count;
   logic [tplr_pkg::POS_W-1:0] base_pos;
   logic                       room;
   logic                       tbl_hit;

   assign busy = q_status.full;

   always_comb begin
      accept     = start && !q_status.full;
      // a load after draining starts a new program
      base_count = draining_ff ? '0 : count_ff;
      base_pos   = draining_ff ? '0 : pos_ff;
      room       = base_count < tplr_pkg::CNT_W'(tplr_pkg::ATOM_DEPTH);
      tbl_hit    = 32'(req_ident) < tplr_pkg::TABLE_DEPTH;

      count_in    = count_ff;
      rp_in       = rp_ff;
      pos_in      = pos_ff;
      draining_in = draining_ff;
      ovf_in      = ovf_ff;
      push        = 1'b0;
      push_cmd    = '0;
      push_cmd.addr    = base_count[tplr_pkg::ATOM_AW-1:0];
      push_cmd.tbl_idx = tplr_pkg::TABLE_AW'(req_ident);

      if (accept) begin
         unique case (tplr_pkg::kind_type'(req_kind))
            tplr_pkg::KIND_DRAIN: begin
               draining_in = 1'b1;
               push        = 1'b1;
               push_cmd.overflowed = ovf_ff;
               push_cmd.addr       = rp_ff[tplr_pkg::ATOM_AW-1:0];
               if (rp_ff >= count_ff) begin
                  push_cmd.op = tplr_pkg::CMD_EMPTY;
               end else begin
                  push_cmd.op         = tplr_pkg::CMD_DRAIN;
                  push_cmd.final_atom = (rp_ff + tplr_pkg::CNT_W'(1)) == count_ff;
                  rp_in               = rp_ff + tplr_pkg::CNT_W'(1);
               end
            end
            tplr_pkg::KIND_BYTE, tplr_pkg::KIND_LREF, tplr_pkg::KIND_VREF,
            tplr_pkg::KIND_NUM: begin
               draining_in = 1'b0;
               rp_in       = draining_ff ? '0 : rp_ff;
               count_in    = base_count;
               push_cmd.op = tplr_pkg::CMD_STORE;
               if (room) begin
                  push     = 1'b1;
                  count_in = base_count + tplr_pkg::CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               pos_in = base_pos + tplr_pkg::POS_W'(tplr_pkg::WORD_BYTES);
               case (tplr_pkg::kind_type'(req_kind))
                  tplr_pkg::KIND_BYTE: begin
                     push_cmd.atom_kind = tplr_pkg::ATOM_BYTE;
                     push_cmd.data = tplr_pkg::DATA_W'(req_payload[tplr_pkg::BYTE_W-1:0]);
                     pos_in = base_pos + tplr_pkg::POS_W'(1);
                  end
                  tplr_pkg::KIND_LREF: begin
                     push_cmd.atom_kind = tplr_pkg::ATOM_LREF;
                     push_cmd.data      = tplr_pkg::DATA_W'(req_ident);
                  end
                  tplr_pkg::KIND_VREF: begin
                     push_cmd.atom_kind = tplr_pkg::ATOM_VREF;
                     push_cmd.data      = tplr_pkg::DATA_W'(req_ident);
                  end
                  default: begin
                     push_cmd.atom_kind = tplr_pkg::ATOM_NUM;
                     push_cmd.data      = req_payload;
                  end
               endcase
            end
            tplr_pkg::KIND_LDEF, tplr_pkg::KIND_VDEF: begin
               draining_in = 1'b0;
               rp_in       = draining_ff ? '0 : rp_ff;
               count_in    = base_count;
               pos_in      = base_pos;
               push        = tbl_hit;
               push_cmd.op = tplr_pkg::CMD_TDEF;
               if (tplr_pkg::kind_type'(req_kind) == tplr_pkg::KIND_LDEF) begin
                  push_cmd.data = tplr_pkg::DATA_W'(base_pos);
               end else begin
                  push_cmd.data = req_payload;
               end
            end
            default: begin
               // unused kind: drop
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rp_ff       <= '0;
         pos_ff      <= '0;
         draining_ff <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rp_ff       <= rp_in;
         pos_ff      <= pos_in;
         draining_ff <= draining_in;
         ovf_ff      <= ovf_in;
      end
   end

endmodule

FILE: sv/tplr_queue.sv
// ---------------------------------------------------------------------------
// tplr_queue
// Short command queue between the front end and the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tplr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tplr_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output tplr_pkg::cmd_type      head,
   output tplr_pkg::q_status_type status
);

   tplr_pkg::cmd_type             entry_ff [tplr_pkg::QUEUE_DEPTH];
   logic [tplr_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tplr_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tplr_pkg::QUEUE_CW-1:0] count_ff, count_in;

   always_comb begin
      status.full  = count_ff == tplr_pkg::QUEUE_CW'(tplr_pkg::QUEUE_DEPTH);
      status.empty = count_ff == '0;
      head         = entry_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + tplr_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in    = pop  ? rd_ptr_ff + tplr_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + tplr_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tplr_pkg::QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TPLR_NEVER(a_q_no_overrun, push && status.full)
   `TPLR_NEVER(a_q_no_underrun, pop && status.empty)

endmodule

FILE: sv/tplr_back.sv
// ---------------------------------------------------------------------------
// tplr_back
// Executes queued commands: atom store, symbol table and drain replay.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tplr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  tplr_pkg::cmd_type            head,
   input  tplr_pkg::q_status_type       q_status,
   output logic                         pop,
   output logic                         rsp_strobe,
   output logic [tplr_pkg::DATA_W-1:0]  rsp_data,
   output logic                         rsp_is_word,
   output logic                         rsp_final_atom,
   output logic                         rsp_none_left,
   output logic                         rsp_overflowed
);

   tplr_pkg::back_state_type state_ff, state_in;

   tplr_pkg::atom_type          atom_mem [tplr_pkg::ATOM_DEPTH];
   logic [tplr_pkg::DATA_W-1:0] table_mem [tplr_pkg::TABLE_DEPTH];
   logic [tplr_pkg::TABLE_DEPTH-1:0] tbl_valid_ff;

   tplr_pkg::atom_type          atom_rd_ff;
   logic [tplr_pkg::DATA_W-1:0] tbl_rd_ff;
   logic                        tbl_vld_rd_ff;
   logic                        ref_ok_ff;
   logic                        final_ff;
   logic                        ovf_ff;

   logic                        atom_we, atom_re, tbl_we, tbl_re, emit, empty_rsp;
   logic [tplr_pkg::TABLE_AW-1:0] ref_idx;
   logic                        ref_ok;
   logic [tplr_pkg::DATA_W-1:0] out_data;
   logic                        out_is_word;

   logic                        strobe_ff;
   logic [tplr_pkg::DATA_W-1:0] data_ff;
   logic                        is_word_ff, final_out_ff, none_left_ff, ovf_out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tplr_pkg::BK_IDLE: begin
            if (!q_status.empty && head.op == tplr_pkg::CMD_DRAIN) begin
               state_in = tplr_pkg::BK_ATOM;
            end
         end
         tplr_pkg::BK_ATOM:  state_in = tplr_pkg::BK_TABLE;
         tplr_pkg::BK_TABLE: state_in = tplr_pkg::BK_IDLE;
         default:            state_in = tplr_pkg::BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop       = 1'b0;
      tbl_re    = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         tplr_pkg::BK_IDLE:  pop    = !q_status.empty;
         tplr_pkg::BK_ATOM:  tbl_re = 1'b1;
         tplr_pkg::BK_TABLE: emit   = 1'b1;
         default: ;
      endcase
      atom_we   = pop && head.op == tplr_pkg::CMD_STORE;
      tbl_we    = pop && head.op == tplr_pkg::CMD_TDEF;
      atom_re   = pop && head.op == tplr_pkg::CMD_DRAIN;
      empty_rsp = pop && head.op == tplr_pkg::CMD_EMPTY;
   end

   always_comb begin
      ref_idx = tplr_pkg::TABLE_AW'(atom_rd_ff.payload[tplr_pkg::IDENT_W-1:0]);
      ref_ok  = 32'(atom_rd_ff.payload[tplr_pkg::IDENT_W-1:0]) < tplr_pkg::TABLE_DEPTH;
   end

   // atom store
   always_ff @(posedge clock) begin
      if (atom_we) begin
         atom_mem[head.addr] <= '{kind: head.atom_kind, payload: head.data};
      end
      if (atom_re) begin
         atom_rd_ff <= atom_mem[head.addr];
         final_ff   <= head.final_atom;
         ovf_ff     <= head.overflowed;
      end
   end

   // symbol table
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[head.tbl_idx] <= head.data;
      end
      if (tbl_re) begin
         tbl_rd_ff     <= table_mem[ref_idx];
         tbl_vld_rd_ff <= tbl_valid_ff[ref_idx];
         ref_ok_ff     <= ref_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (tbl_we) begin
         tbl_valid_ff[head.tbl_idx] <= 1'b1;
      end
   end

   always_comb begin
      out_data    = atom_rd_ff.payload;
      out_is_word = 1'b1;
      unique case (atom_rd_ff.kind) inside
         tplr_pkg::ATOM_BYTE: begin
            out_data = tplr_pkg::DATA_W'(atom_rd_ff.payload[tplr_pkg::BYTE_W-1:0]);
            out_is_word = 1'b0;
         end
         tplr_pkg::ATOM_LREF, tplr_pkg::ATOM_VREF: begin
            out_data = (ref_ok_ff && tbl_vld_rd_ff) ? tbl_rd_ff : '0;
         end
         default: out_data = atom_rd_ff.payload;
      endcase
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_ff      <= out_data;
         is_word_ff   <= out_is_word;
         final_out_ff <= final_ff;
         none_left_ff <= 1'b0;
         ovf_out_ff   <= ovf_ff;
      end else if (empty_rsp) begin
         data_ff      <= '0;
         is_word_ff   <= 1'b0;
         final_out_ff <= 1'b0;
         none_left_ff <= 1'b1;
         ovf_out_ff   <= head.overflowed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tplr_pkg::BK_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= emit || empty_rsp;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_data       = data_ff;
   assign rsp_is_word    = is_word_ff;
   assign rsp_final_atom = final_out_ff;
   assign rsp_none_left  = none_left_ff;
   assign rsp_overflowed = ovf_out_ff;

   `TPLR_ASSERT(a_bk_atom_to_table, state_ff == tplr_pkg::BK_ATOM |=> state_ff == tplr_pkg::BK_TABLE)
   `TPLR_ASSERT(a_bk_table_emits, state_ff == tplr_pkg::BK_TABLE |=> rsp_strobe)
   `TPLR_ASSERT(a_bk_empty_zero, rsp_strobe && rsp_none_left |-> rsp_data == '0 && !rsp_is_word)

endmodule

FILE: sv/two_pass_label_resolver.sv
// ---------------------------------------------------------------------------
// two_pass_label_resolver
// Two-pass assembler label resolution: load atoms, then drain resolved bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_kind/req_ident/req_payload and raise start; the
//   request is taken at a rising edge where start is high and busy is low.
//   Kinds byte, label ref, var ref and number are stored; label and variable
//   definitions update the symbol table; a drain replays one stored atom.
//   Result channel: one result per drain, shown for exactly one cycle with
//   rsp_strobe high. The receiver cannot stall, so results are never held.
//   Result path: a drain with an atom left passes the command queue, then the
//   atom read, the symbol table read and the output register; a drain with
//   nothing left shows its result in the cycle after the queue hands it over.
//   Throughput: loads and definitions retire one per cycle while no drain
//   holds the back end; a drain holds the back end through its atom read and
//   its symbol table read before the next command is taken.
//   busy rises when the four-entry command queue is full.
//   Reset clears counters, flags, queue and the table valid bits; the symbol
//   table then reads as all zero. The atom store needs no clearing.
// ---------------------------------------------------------------------------
module two_pass_label_resolver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tplr_pkg::KIND_W-1:0]   req_kind,
   input  logic [tplr_pkg::IDENT_W-1:0]  req_ident,
   input  logic [tplr_pkg::DATA_W-1:0]   req_payload,
   output logic                          rsp_strobe,
   output logic [tplr_pkg::DATA_W-1:0]   rsp_data,
   output logic                          rsp_is_word,
   output logic                          rsp_final_atom,
   output logic                          rsp_none_left,
   output logic                          rsp_overflowed
);

   logic                   push;
   logic                   pop;
   tplr_pkg::cmd_type      push_cmd;
   tplr_pkg::cmd_type      head;
   tplr_pkg::q_status_type q_status;

   // Front end: classify the request, advance position and counters, and
   // hand a command to the queue.
   tplr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_kind    (req_kind),
      .req_ident   (req_ident),
      .req_payload (req_payload),
      .q_status    (q_status),
      .busy        (busy),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Queue: decouple acceptance from execution.
   tplr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // Back end: write stores, resolve drains and drive the result register.
   tplr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .rsp_is_word    (rsp_is_word),
      .rsp_final_atom (rsp_final_atom),
      .rsp_none_left  (rsp_none_left),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule
